>>> hdl/dmwc_pkg.sv
// shared sizes, command codes and controller/datapath interface types
// for the direct-mapped write-back cache
// no dependencies
package dmwc_pkg;

    // address split: tag | index | offset
    localparam int ADDR_W       = 20;
    localparam int OFF_W        = 4;
    localparam int IDX_W        = 4;
    localparam int TAG_W        = ADDR_W - IDX_W - OFF_W;
    localparam int NUM_LINES    = 1 << IDX_W;
    localparam int LINE_BYTES   = 1 << OFF_W;
    localparam int LINE_W       = LINE_BYTES * 8;
    localparam int ACCESS_BYTES = 4;

    // backing memory lines are addressed by {tag, index}
    localparam int MEM_AW       = TAG_W + IDX_W;
    localparam int MEM_LINES    = 1 << MEM_AW;

    // access command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef logic [7:0] byte_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // zero one backing memory line
        logic load_in;    // capture an input beat
        logic lookup;     // tag compare, victim write-back, fill read
        logic fill;       // install the fetched line
        logic access;     // byte read/write and result load
    } dmwc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // clearing pass at its last line
        logic lookup_hit; // captured address hits a valid line
        logic out_free;   // result register can take a beat
    } dmwc_stat_t;

endpackage

>>> hdl/dmwc_ctrl.sv
// controller state machine of the cache: memory clear, lookup, fill, access
// depends on dmwc_pkg
module dmwc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dmwc_pkg::dmwc_stat_t stat,
    output dmwc_pkg::dmwc_cmd_t  cmd
);
    import dmwc_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LOOKUP = 3'd2;
    localparam logic [2:0] ST_FILL   = 3'd3;
    localparam logic [2:0] ST_ACCESS = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = stat.lookup_hit ? ST_ACCESS : ST_FILL;
            end
            ST_FILL: begin
                cmd.fill   = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                // hold until the result register frees up
                if (stat.out_free) begin
                    cmd.access = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/dmwc_datapath.sv
// cache datapath: input capture, tag/valid/dirty/data arrays, backing memory,
// clear counter and result register
// depends on dmwc_pkg
module dmwc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dmwc_pkg::dmwc_cmd_t           cmd,
    output dmwc_pkg::dmwc_stat_t          stat,
    input  logic                          s_command,
    input  logic [dmwc_pkg::ADDR_W-1:0]   s_address,
    input  logic [7:0]                    s_wr_byte_0,
    input  logic [7:0]                    s_wr_byte_1,
    input  logic [7:0]                    s_wr_byte_2,
    input  logic [7:0]                    s_wr_byte_3,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_wrote_back,
    output logic [7:0]                    m_rd_byte_0,
    output logic [7:0]                    m_rd_byte_1,
    output logic [7:0]                    m_rd_byte_2,
    output logic [7:0]                    m_rd_byte_3
);
    import dmwc_pkg::*;

    // captured input beat
    logic              in_cmd_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    byte_t             in_wr_reg [ACCESS_BYTES];

    logic [OFF_W-1:0] in_off;
    logic [IDX_W-1:0] in_idx;
    logic [TAG_W-1:0] in_tag;

    // line state
    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] dirty_reg;
    logic [TAG_W-1:0]     tag_reg  [NUM_LINES];
    logic [LINE_W-1:0]    data_reg [NUM_LINES];

    // backing memory
    logic [LINE_W-1:0] mem [MEM_LINES];
    logic [LINE_W-1:0] mem_rd_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [LINE_W-1:0] mem_wdata;
    logic [MEM_AW-1:0] clr_cnt_reg;

    // lookup outcome
    logic lookup_hit;
    logic victim_dirty;
    logic hit_reg;
    logic wb_reg;

    // line access
    logic [LINE_W-1:0] cur_line;
    logic [LINE_W-1:0] line_wr_data;
    byte_t             rd_bytes [ACCESS_BYTES];

    // result register
    logic  m_valid_reg;
    logic  res_hit_reg;
    logic  res_wb_reg;
    byte_t res_rd_reg [ACCESS_BYTES];

    assign in_off = in_addr_reg[OFF_W-1:0];
    assign in_idx = in_addr_reg[OFF_W +: IDX_W];
    assign in_tag = in_addr_reg[ADDR_W-1 -: TAG_W];

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg    <= s_command;
            in_addr_reg   <= s_address;
            in_wr_reg[0]  <= s_wr_byte_0;
            in_wr_reg[1]  <= s_wr_byte_1;
            in_wr_reg[2]  <= s_wr_byte_2;
            in_wr_reg[3]  <= s_wr_byte_3;
        end
    end

    // tag compare and victim check
    assign lookup_hit   = valid_reg[in_idx] && (tag_reg[in_idx] == in_tag);
    assign victim_dirty = valid_reg[in_idx] && dirty_reg[in_idx] && !lookup_hit;

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            hit_reg <= lookup_hit;
            wb_reg  <= victim_dirty;
        end
    end

    // valid and dirty bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
        end else begin
            if (cmd.fill) begin
                valid_reg[in_idx] <= 1'b1;
                dirty_reg[in_idx] <= 1'b0;
            end
            if (cmd.access && (in_cmd_reg == CMD_WRITE)) begin
                dirty_reg[in_idx] <= 1'b1;
            end
        end
    end

    // byte lanes of the addressed line, offset wraps within the line
    assign cur_line = data_reg[in_idx];

    always_comb begin
        logic [OFF_W-1:0] pos;
        line_wr_data = cur_line;
        for (int k = 0; k < ACCESS_BYTES; k++) begin
            pos = in_off + OFF_W'(k);
            line_wr_data[{pos, 3'b000} +: 8] = in_wr_reg[k];
            rd_bytes[k] = cur_line[{pos, 3'b000} +: 8];
        end
    end

    // tag and data arrays
    always_ff @(posedge aclk) begin
        if (cmd.fill) begin
            tag_reg[in_idx]  <= in_tag;
            data_reg[in_idx] <= mem_rd_reg;
        end else if (cmd.access && (in_cmd_reg == CMD_WRITE)) begin
            data_reg[in_idx] <= line_wr_data;
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
        end
    end

    // memory write port: clear sweep or victim write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {tag_reg[in_idx], in_idx};
        mem_wdata = cur_line;
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (cmd.lookup && victim_dirty) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // memory read port: fetch the line for a possible fill
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            mem_rd_reg <= mem[{in_tag, in_idx}];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.access) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            res_hit_reg <= hit_reg;
            res_wb_reg  <= wb_reg;
            for (int k = 0; k < ACCESS_BYTES; k++) begin
                res_rd_reg[k] <= (in_cmd_reg == CMD_WRITE) ? 8'h00 : rd_bytes[k];
            end
        end
    end

    // status to the controller
    assign stat.clr_last   = (clr_cnt_reg == {MEM_AW{1'b1}});
    assign stat.lookup_hit = lookup_hit;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hit        = res_hit_reg;
    assign m_wrote_back = res_wb_reg;
    assign m_rd_byte_0  = res_rd_reg[0];
    assign m_rd_byte_1  = res_rd_reg[1];
    assign m_rd_byte_2  = res_rd_reg[2];
    assign m_rd_byte_3  = res_rd_reg[3];

endmodule

>>> hdl/direct_mapped_writeback_cache.sv
// direct-mapped write-back write-allocate cache, 16 lines of 16 bytes
// result is registered: a hit runs lookup then access, a miss runs lookup, fill, access
// one item in flight: the next input beat is taken only after the lookup / fill /
//   access sequence has loaded the result, which waits while a result beat is stalled
// reset: a clearing pass zeroes all 65536 backing memory lines, one per
//   cycle, and s_ready stays low until the pass ends
module direct_mapped_writeback_cache (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic [dmwc_pkg::ADDR_W-1:0] s_address,
    input  logic [7:0]                  s_wr_byte_0,
    input  logic [7:0]                  s_wr_byte_1,
    input  logic [7:0]                  s_wr_byte_2,
    input  logic [7:0]                  s_wr_byte_3,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic                        m_wrote_back,
    output logic [7:0]                  m_rd_byte_0,
    output logic [7:0]                  m_rd_byte_1,
    output logic [7:0]                  m_rd_byte_2,
    output logic [7:0]                  m_rd_byte_3
);
    import dmwc_pkg::*;

    dmwc_cmd_t  cmd;
    dmwc_stat_t stat;

    // sequencer
    dmwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arrays, memory and result register
    dmwc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_command    (s_command),
        .s_address    (s_address),
        .s_wr_byte_0  (s_wr_byte_0),
        .s_wr_byte_1  (s_wr_byte_1),
        .s_wr_byte_2  (s_wr_byte_2),
        .s_wr_byte_3  (s_wr_byte_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_wrote_back (m_wrote_back),
        .m_rd_byte_0  (m_rd_byte_0),
        .m_rd_byte_1  (m_rd_byte_1),
        .m_rd_byte_2  (m_rd_byte_2),
        .m_rd_byte_3  (m_rd_byte_3)
    );

endmodule

>>> hdl/dmwc_checker.sv
// port-level checks of the cache over time, bound to the top level
// depends on direct_mapped_writeback_cache
module dmwc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_hit,
    input logic       m_wrote_back,
    input logic [7:0] m_rd_byte_0,
    input logic [7:0] m_rd_byte_1,
    input logic [7:0] m_rd_byte_2,
    input logic [7:0] m_rd_byte_3
);

    // no result beat right out of reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_wrote_back)
            && $stable(m_rd_byte_0) && $stable(m_rd_byte_1)
            && $stable(m_rd_byte_2) && $stable(m_rd_byte_3))
        else $error("stalled result beat changed");

    // a write-back only happens on a miss
    a_wb_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_wrote_back))
        else $error("write-back reported on a hit");

    // one item in flight: input closes after each accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input beat accepted while an item is in flight");

    // a new result beat must trace back to an accepted input beat
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3) || $past(s_valid && s_ready, 4))
        else $error("result beat without matching input beat");

endmodule

bind direct_mapped_writeback_cache dmwc_checker u_dmwc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hit        (m_hit),
    .m_wrote_back (m_wrote_back),
    .m_rd_byte_0  (m_rd_byte_0),
    .m_rd_byte_1  (m_rd_byte_1),
    .m_rd_byte_2  (m_rd_byte_2),
    .m_rd_byte_3  (m_rd_byte_3)
);

>>> bench/tb_direct_mapped_writeback_cache.sv
// testbench for direct_mapped_writeback_cache: directed and random accesses with
// a line-level cache predictor held in a scoreboard class, random gaps and stalls
// depends on hdl/dmwc_pkg.sv and hdl/direct_mapped_writeback_cache.sv
module tb_direct_mapped_writeback_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import dmwc_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 4;
    // the clearing pass after reset keeps s_ready low while it sweeps all MEM_LINES lines
    localparam int IDLE_LIMIT   = 3 * MEM_LINES;
    localparam int DRAIN_CYCLES = 10;

    typedef logic [LINE_W-1:0] line_t;

    typedef struct packed {
        logic            hit;
        logic            wrote_back;
        byte_t [3:0]     rd_bytes;
    } access_result_t;

    // predicts each access and checks results in order
    class cache_scoreboard;
        logic [NUM_LINES-1:0] valid_bits;
        logic [NUM_LINES-1:0] dirty_bits;
        logic [TAG_W-1:0]     tag_store[NUM_LINES];
        line_t                line_store[NUM_LINES];
        line_t                memory_lines[logic [MEM_AW-1:0]];
        access_result_t       pending_results[$];
        int                   failures;

        function new();
            valid_bits = '0;
            dirty_bits = '0;
            failures   = 0;
            foreach (tag_store[i]) begin
                tag_store[i]  = '0;
                line_store[i] = '0;
            end
        endfunction

        // apply one accepted access to the shadow cache and queue its result
        function void note_access(logic cmd, logic [ADDR_W-1:0] addr, byte_t [3:0] wr);
            logic [OFF_W-1:0] off;
            logic [OFF_W-1:0] pos;
            logic [IDX_W-1:0] idx;
            logic [TAG_W-1:0] tg;
            access_result_t   res;
            off = addr[OFF_W-1:0];
            idx = addr[OFF_W +: IDX_W];
            tg  = addr[ADDR_W-1 -: TAG_W];
            res = '0;
            if (valid_bits[idx] && tag_store[idx] == tg) begin
                res.hit = 1'b1;
            end else begin
                // dirty victim goes back to memory before the fill
                if (valid_bits[idx] && dirty_bits[idx]) begin
                    memory_lines[{tag_store[idx], idx}] = line_store[idx];
                    res.wrote_back = 1'b1;
                end
                if (memory_lines.exists({tg, idx}))
                    line_store[idx] = memory_lines[{tg, idx}];
                else
                    line_store[idx] = '0;
                valid_bits[idx] = 1'b1;
                dirty_bits[idx] = 1'b0;
                tag_store[idx]  = tg;
            end
            // byte position wraps inside the line
            for (int k = 0; k < ACCESS_BYTES; k++) begin
                pos = off + OFF_W'(k);
                if (cmd == CMD_WRITE)
                    line_store[idx][pos*8 +: 8] = wr[k];
                else
                    res.rd_bytes[k] = line_store[idx][pos*8 +: 8];
            end
            if (cmd == CMD_WRITE)
                dirty_bits[idx] = 1'b1;
            pending_results.insert(pending_results.size(), res);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(access_result_t got);
            access_result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with no access outstanding");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                failures++;
            end
            if (got.wrote_back !== want.wrote_back) begin
                $error("wrote_back: expected %0d, got %0d", want.wrote_back, got.wrote_back);
                failures++;
            end
            for (int k = 0; k < ACCESS_BYTES; k++) begin
                if (got.rd_bytes[k] !== want.rd_bytes[k]) begin
                    $error("rd_byte_%0d: expected 0x%02h, got 0x%02h",
                           k, want.rd_bytes[k], got.rd_bytes[k]);
                    failures++;
                end
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_command    = CMD_READ;
    logic [ADDR_W-1:0] s_address    = '0;
    logic [7:0]        s_wr_byte_0  = '0;
    logic [7:0]        s_wr_byte_1  = '0;
    logic [7:0]        s_wr_byte_2  = '0;
    logic [7:0]        s_wr_byte_3  = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_hit;
    logic              m_wrote_back;
    logic [7:0]        m_rd_byte_0;
    logic [7:0]        m_rd_byte_1;
    logic [7:0]        m_rd_byte_2;
    logic [7:0]        m_rd_byte_3;

    cache_scoreboard   sb;
    bit                tx_calm = 1'b1;
    bit                rx_calm = 1'b1;
    int                rx_hold = 0;
    int                idle_cycles = 0;
    logic [TAG_W-1:0]  tag_pool[4];

    direct_mapped_writeback_cache dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_address    (s_address),
        .s_wr_byte_0  (s_wr_byte_0),
        .s_wr_byte_1  (s_wr_byte_1),
        .s_wr_byte_2  (s_wr_byte_2),
        .s_wr_byte_3  (s_wr_byte_3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_wrote_back (m_wrote_back),
        .m_rd_byte_0  (m_rd_byte_0),
        .m_rd_byte_1  (m_rd_byte_1),
        .m_rd_byte_2  (m_rd_byte_2),
        .m_rd_byte_3  (m_rd_byte_3)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check beats, randomize ready, watch for a hang
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_hit, m_wrote_back,
                             m_rd_byte_3, m_rd_byte_2, m_rd_byte_1, m_rd_byte_0});

        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_calm) begin
            m_ready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                rx_hold <= $urandom_range(10, 40);
                m_ready <= 1'b0;
            end else begin
                m_ready <= (r >= 30);
            end
        end

        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("** direct_mapped_writeback_cache: FAILED **");
            $finish;
        end
    end

    // gap after a beat: mostly none or short, now and then long
    function automatic int sender_gap();
        int r;
        if (tx_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 50);
    endfunction

    // drive one access beat, wait for it to be taken, then idle for the given gap
    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input byte_t [3:0] wr, input int gap);
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_address   <= addr;
        s_wr_byte_0 <= wr[0];
        s_wr_byte_1 <= wr[1];
        s_wr_byte_2 <= wr[2];
        s_wr_byte_3 <= wr[3];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_access(cmd, addr, wr);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    // address mostly from a small tag pool so lines conflict and hit
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if ($urandom_range(0, 99) < 85)
            a[ADDR_W-1 -: TAG_W] = tag_pool[$urandom_range(0, 3)];
        return a;
    endfunction

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, wrap at line end, hits, clean and dirty misses
        send_access(CMD_READ,  20'h00000, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'h00000, 32'hFFFF_FFFF, 0);
        send_access(CMD_READ,  20'h00000, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'hFFFFF, 32'h0403_0201, 0);
        send_access(CMD_READ,  20'hFFFFE, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'hFFFFC, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'h00F00, 32'h8899_AABB, 0);
        send_access(CMD_READ,  20'hFFFF0, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'hFFFFD, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'h0000D, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'h10000, 32'h1234_5678, 0);
        send_access(CMD_READ,  20'h00000, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'h10000, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'hAAAAA, 32'hFF00_55AA, 0);
        send_access(CMD_WRITE, 20'h55555, 32'h00FF_AA55, 0);
        send_access(CMD_READ,  20'hAAAA8, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'h5555C, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 20'hFFF0F, 32'hDEAD_BEEF, 0);
        send_access(CMD_READ,  20'h0000F, 32'h0000_0000, 0);
        send_access(CMD_READ,  20'hFFF0F, 32'h0000_0000, 1);
        wait_drained();

        // random phases with different gap and stall mixes
        for (int ph = 0; ph < PHASES; ph++) begin
            tx_calm = (ph == 0) || (ph == 2);
            rx_calm = (ph == 0) || (ph == 3);
            foreach (tag_pool[i])
                tag_pool[i] = TAG_W'($urandom);
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                logic              cmd;
                logic [ADDR_W-1:0] addr;
                byte_t [3:0]       wr;
                int                gap;
                cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                addr = pick_address();
                wr   = $urandom;
                gap  = sender_gap();
                if (n == RANDOM_ITEMS / PHASES - 1 && gap == 0)
                    gap = 1;
                send_access(cmd, addr, wr, gap);
            end
            // hold off the sender until the cache has answered everything
            wait_drained();
        end

        rx_calm = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.outstanding() != 0) begin
            $error("%0d results never arrived", sb.outstanding());
            sb.failures++;
        end
        if (sb.failures == 0)
            $display("** direct_mapped_writeback_cache: PASSED **");
        else
            $display("** direct_mapped_writeback_cache: FAILED **");
        $finish;
    end

endmodule
